FILE: hw/rtl/mua_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mua_pkg
// Shared constants, codes and types of the mask upscale / alpha apply block.
// ----------------------------------------------------------------------------
package mua_pkg;

  // default sizing
  localparam int MASK_DEPTH_DEF    = 65536;
  localparam int MAX_FRAME_DIM_DEF = 4096;

  // fixed field widths
  localparam int FRAME_W     = 13;
  localparam int MDIM_W      = 9;
  localparam int MIDX_W      = 8;
  localparam int MPOS_W      = 16;
  localparam int MVAL_W      = 18;
  localparam int CH_W        = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int MASK_DIM_MAX = 256;

  // reset values of the configuration registers
  localparam logic [FRAME_W-1:0] FRAME_W_RST = 13'd1280;
  localparam logic [FRAME_W-1:0] FRAME_H_RST = 13'd720;

  // 1.0 in the mask sample format
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // request opcodes
  localparam logic OP_MASK_WR = 1'b0;
  localparam logic OP_PIXEL   = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_W = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_H = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_W  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_H  = 3'd4;

  // ratio recompute sequencer
  typedef enum logic [1:0] {
    RC_IDLE,
    RC_START,
    RC_RUN
  } rc_state_t;

endpackage

FILE: hw/rtl/mask_upscale_alpha_apply_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mask_upscale_alpha_apply_core
// Nearest-neighbor matte upscale: alpha from the mask sample when enabled.
// ----------------------------------------------------------------------------
// Takes one request per clock while in_stall is low, mask sample writes and
// frame pixels alike, and returns one result per pixel via stage 1 and the
// result register. The mask column and row of each pixel are tracked
// incrementally as quotient/remainder pairs, so no division sits in the
// pixel path. Any configuration write starts a recompute of those pairs and
// of the per-step increments in four bit-serial dividers; in_stall stays
// high until their results are loaded. The mask store is a single memory
// of MASK_DEPTH 8-bit entries holding the ready-scaled alpha.
// ----------------------------------------------------------------------------
module mask_upscale_alpha_apply_core #(
  parameter int MASK_DEPTH    = mua_pkg::MASK_DEPTH_DEF,
  parameter int MAX_FRAME_DIM = mua_pkg::MAX_FRAME_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [mua_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mua_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // requests
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_op,
  input  logic [mua_pkg::MPOS_W-1:0]        in_mask_index,
  input  logic signed [mua_pkg::MVAL_W-1:0] in_mask_value,
  input  logic [mua_pkg::CH_W-1:0]          in_blue,
  input  logic [mua_pkg::CH_W-1:0]          in_green,
  input  logic [mua_pkg::CH_W-1:0]          in_red,
  input  logic [mua_pkg::CH_W-1:0]          in_alpha_in,
  // results
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mua_pkg::CH_W-1:0]          out_blue,
  output logic [mua_pkg::CH_W-1:0]          out_green,
  output logic [mua_pkg::CH_W-1:0]          out_red,
  output logic [mua_pkg::CH_W-1:0]          out_alpha,
  output logic                              out_frame_end
);

  localparam int FRAME_W = mua_pkg::FRAME_W;
  localparam int MDIM_W  = mua_pkg::MDIM_W;
  localparam int MIDX_W  = mua_pkg::MIDX_W;
  localparam int MPOS_W  = mua_pkg::MPOS_W;
  localparam int CH_W    = mua_pkg::CH_W;
  localparam int CNT_W   = $clog2(MAX_FRAME_DIM);
  localparam int DIM_W   = $clog2(MAX_FRAME_DIM + 1);
  localparam int CMP_W   = (FRAME_W > DIM_W) ? FRAME_W : DIM_W;
  localparam int ACC_W   = CNT_W + MDIM_W;
  localparam int MADDR_W = $clog2(MASK_DEPTH);

  // ---------------- configuration registers ----------------
  logic               enable_r;
  logic [FRAME_W-1:0] frame_w_r;
  logic [FRAME_W-1:0] frame_h_r;
  logic [MDIM_W-1:0]  mask_w_r;
  logic [MDIM_W-1:0]  mask_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      frame_w_r <= mua_pkg::FRAME_W_RST;
      frame_h_r <= mua_pkg::FRAME_H_RST;
      mask_w_r  <= '0;
      mask_h_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mua_pkg::CFG_ENABLE:  enable_r  <= cfg_wdata[0];
        mua_pkg::CFG_FRAME_W: frame_w_r <= cfg_wdata[FRAME_W-1:0];
        mua_pkg::CFG_FRAME_H: frame_h_r <= cfg_wdata[FRAME_W-1:0];
        mua_pkg::CFG_MASK_W:  mask_w_r  <= cfg_wdata[MDIM_W-1:0];
        mua_pkg::CFG_MASK_H:  mask_h_r  <= cfg_wdata[MDIM_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated sizes
  logic [CMP_W-1:0]  fw_ext;
  logic [CMP_W-1:0]  fh_ext;
  logic [DIM_W-1:0]  fw_sat;
  logic [DIM_W-1:0]  fh_sat;
  logic [MDIM_W-1:0] mw_sat;
  logic [MDIM_W-1:0] mh_sat;
  logic              apply;

  assign fw_ext = CMP_W'(frame_w_r);
  assign fh_ext = CMP_W'(frame_h_r);

  always_comb begin
    if (fw_ext == '0) begin
      fw_sat = DIM_W'(1);
    end else if (fw_ext > CMP_W'(MAX_FRAME_DIM)) begin
      fw_sat = DIM_W'(MAX_FRAME_DIM);
    end else begin
      fw_sat = DIM_W'(fw_ext);
    end
    if (fh_ext == '0) begin
      fh_sat = DIM_W'(1);
    end else if (fh_ext > CMP_W'(MAX_FRAME_DIM)) begin
      fh_sat = DIM_W'(MAX_FRAME_DIM);
    end else begin
      fh_sat = DIM_W'(fh_ext);
    end
    mw_sat = (mask_w_r > MDIM_W'(mua_pkg::MASK_DIM_MAX)) ?
             MDIM_W'(mua_pkg::MASK_DIM_MAX) : mask_w_r;
    mh_sat = (mask_h_r > MDIM_W'(mua_pkg::MASK_DIM_MAX)) ?
             MDIM_W'(mua_pkg::MASK_DIM_MAX) : mask_h_r;
  end

  assign apply = enable_r && (mw_sat != '0) && (mh_sat != '0);

  // ---------------- position state ----------------
  logic [CNT_W-1:0]  x_r;
  logic [CNT_W-1:0]  y_r;
  logic [ACC_W-1:0]  cq_r;    // floor(x*mw/fw)
  logic [DIM_W-1:0]  cr_r;
  logic [ACC_W-1:0]  rq_r;    // floor(y*mh/fh)
  logic [DIM_W-1:0]  rr_r;
  logic [MDIM_W-1:0] csq_r;   // per-column increment, quotient and remainder
  logic [DIM_W-1:0]  csr_r;
  logic [MDIM_W-1:0] rsq_r;
  logic [DIM_W-1:0]  rsr_r;

  // ---------------- ratio recompute ----------------
  mua_pkg::rc_state_t rc_state_r;
  mua_pkg::rc_state_t rc_state_nxt;
  logic               div_start;
  logic               rc_load;
  logic               busy;

  logic [ACC_W-1:0] cq_div, rq_div, csq_div, rsq_div;
  logic [DIM_W-1:0] cr_div, rr_div, csr_div, rsr_div;
  logic             done_c, done_r, done_cs, done_rs;
  logic             div_done;

  assign div_done = done_c && done_r && done_cs && done_rs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_state_r <= mua_pkg::RC_IDLE;
    end else begin
      rc_state_r <= rc_state_nxt;
    end
  end

  always_comb begin
    rc_state_nxt = rc_state_r;
    div_start    = 1'b0;
    rc_load      = 1'b0;
    case (rc_state_r)
      mua_pkg::RC_IDLE: begin
        if (cfg_we) rc_state_nxt = mua_pkg::RC_START;
      end
      mua_pkg::RC_START: begin
        div_start = 1'b1;
        if (!cfg_we) rc_state_nxt = mua_pkg::RC_RUN;
      end
      mua_pkg::RC_RUN: begin
        if (cfg_we) begin
          rc_state_nxt = mua_pkg::RC_START;
        end else if (div_done) begin
          rc_load      = 1'b1;
          rc_state_nxt = mua_pkg::RC_IDLE;
        end
      end
      default: rc_state_nxt = mua_pkg::RC_IDLE;
    endcase
  end

  assign busy = (rc_state_r != mua_pkg::RC_IDLE);

  mua_div #(.DVD_W(ACC_W), .DVS_W(DIM_W)) u_div_col (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (ACC_W'(ACC_W'(x_r) * ACC_W'(mw_sat))),
    .divisor   (fw_sat),
    .quotient  (cq_div),
    .remainder (cr_div),
    .done      (done_c)
  );

  mua_div #(.DVD_W(ACC_W), .DVS_W(DIM_W)) u_div_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (ACC_W'(ACC_W'(y_r) * ACC_W'(mh_sat))),
    .divisor   (fh_sat),
    .quotient  (rq_div),
    .remainder (rr_div),
    .done      (done_r)
  );

  mua_div #(.DVD_W(ACC_W), .DVS_W(DIM_W)) u_div_col_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (ACC_W'(mw_sat)),
    .divisor   (fw_sat),
    .quotient  (csq_div),
    .remainder (csr_div),
    .done      (done_cs)
  );

  mua_div #(.DVD_W(ACC_W), .DVS_W(DIM_W)) u_div_row_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (ACC_W'(mh_sat)),
    .divisor   (fh_sat),
    .quotient  (rsq_div),
    .remainder (rsr_div),
    .done      (done_rs)
  );

  // ---------------- handshake ----------------
  logic s1_valid_r;
  logic out_valid_r;
  logic adv1, adv2;
  logic in_acc, pix_acc, wr_acc;

  assign adv2     = !out_valid_r || !out_stall;
  assign adv1     = !s1_valid_r || adv2;
  assign in_stall = busy || !adv1;
  assign in_acc   = in_valid && !in_stall;
  assign pix_acc  = in_acc && (in_op == mua_pkg::OP_PIXEL);
  assign wr_acc   = in_acc && (in_op == mua_pkg::OP_MASK_WR) &&
                    (32'(in_mask_index) < 32'(MASK_DEPTH));

  // ---------------- position advance ----------------
  logic              last_col, last_row;
  logic [DIM_W:0]    c_sum, r_sum;
  logic              c_wrap, r_wrap;
  logic [ACC_W-1:0]  cq_nxt, rq_nxt;
  logic [DIM_W-1:0]  cr_nxt, rr_nxt;

  assign last_col = (32'(x_r) + 32'd1) >= 32'(fw_sat);
  assign last_row = (32'(y_r) + 32'd1) >= 32'(fh_sat);
  assign c_sum    = (DIM_W+1)'(cr_r) + (DIM_W+1)'(csr_r);
  assign r_sum    = (DIM_W+1)'(rr_r) + (DIM_W+1)'(rsr_r);
  assign c_wrap   = c_sum >= (DIM_W+1)'(fw_sat);
  assign r_wrap   = r_sum >= (DIM_W+1)'(fh_sat);
  assign cr_nxt   = c_wrap ? DIM_W'(c_sum - (DIM_W+1)'(fw_sat)) : DIM_W'(c_sum);
  assign rr_nxt   = r_wrap ? DIM_W'(r_sum - (DIM_W+1)'(fh_sat)) : DIM_W'(r_sum);
  assign cq_nxt   = cq_r + ACC_W'(csq_r) + ACC_W'(c_wrap);
  assign rq_nxt   = rq_r + ACC_W'(rsq_r) + ACC_W'(r_wrap);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r   <= '0;
      y_r   <= '0;
      cq_r  <= '0;
      cr_r  <= '0;
      rq_r  <= '0;
      rr_r  <= '0;
      csq_r <= '0;
      csr_r <= '0;
      rsq_r <= '0;
      rsr_r <= '0;
    end else if (rc_load) begin
      cq_r  <= cq_div;
      cr_r  <= cr_div;
      rq_r  <= rq_div;
      rr_r  <= rr_div;
      csq_r <= MDIM_W'(csq_div);
      csr_r <= csr_div;
      rsq_r <= MDIM_W'(rsq_div);
      rsr_r <= rsr_div;
    end else if (pix_acc) begin
      if (last_col) begin
        x_r  <= '0;
        cq_r <= '0;
        cr_r <= '0;
        if (last_row) begin
          y_r  <= '0;
          rq_r <= '0;
          rr_r <= '0;
        end else begin
          y_r  <= y_r + CNT_W'(1);
          rq_r <= rq_nxt;
          rr_r <= rr_nxt;
        end
      end else begin
        x_r  <= x_r + CNT_W'(1);
        cq_r <= cq_nxt;
        cr_r <= cr_nxt;
      end
    end
  end

  // ---------------- mask lookup ----------------
  logic [MIDX_W-1:0]  mx, my;
  logic [MPOS_W-1:0]  pos;
  logic               pos_ok;

  assign mx     = (cq_r >= ACC_W'(mw_sat)) ? MIDX_W'(mw_sat - MDIM_W'(1)) : MIDX_W'(cq_r);
  assign my     = (rq_r >= ACC_W'(mh_sat)) ? MIDX_W'(mh_sat - MDIM_W'(1)) : MIDX_W'(rq_r);
  assign pos    = MPOS_W'(MPOS_W'(my) * MPOS_W'(mw_sat)) + MPOS_W'(mx);
  assign pos_ok = 32'(pos) < 32'(MASK_DEPTH);

  // mask sample clamped to [0, 1.0] and scaled to alpha on write
  logic [16:0]    wr_sample;
  logic [24:0]    wr_prod;
  logic [CH_W-1:0] wr_alpha;

  always_comb begin
    if (in_mask_value[mua_pkg::MVAL_W-1]) begin
      wr_sample = '0;
    end else if (in_mask_value[16:0] > mua_pkg::ONE_Q16) begin
      wr_sample = mua_pkg::ONE_Q16;
    end else begin
      wr_sample = in_mask_value[16:0];
    end
    wr_prod  = (25'(wr_sample) << 8) - 25'(wr_sample);
    wr_alpha = wr_prod[23:16];
  end

  logic [CH_W-1:0] mask_mem [MASK_DEPTH];
  logic [CH_W-1:0] mem_rd_r;

  always_ff @(posedge clk) begin
    if (wr_acc) begin
      mask_mem[MADDR_W'(in_mask_index)] <= wr_alpha;
    end
    if (adv1) begin
      mem_rd_r <= mask_mem[MADDR_W'(pos)];
    end
  end

  // ---------------- stage 1 ----------------
  logic [CH_W-1:0] s1_blue_r, s1_green_r, s1_red_r, s1_alpha_r;
  logic            s1_apply_r, s1_pos_ok_r, s1_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv1) begin
      s1_valid_r <= pix_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_blue_r   <= in_blue;
      s1_green_r  <= in_green;
      s1_red_r    <= in_red;
      s1_alpha_r  <= in_alpha_in;
      s1_apply_r  <= apply;
      s1_pos_ok_r <= pos_ok;
      s1_end_r    <= last_col && last_row;
    end
  end

  // ---------------- result register ----------------
  logic [CH_W-1:0] out_blue_r, out_green_r, out_red_r, out_alpha_r;
  logic            out_end_r;
  logic [CH_W-1:0] alpha_sel;

  always_comb begin
    if (!s1_apply_r) begin
      alpha_sel = s1_alpha_r;
    end else if (s1_pos_ok_r) begin
      alpha_sel = mem_rd_r;
    end else begin
      alpha_sel = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv2) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      out_blue_r  <= s1_blue_r;
      out_green_r <= s1_green_r;
      out_red_r   <= s1_red_r;
      out_alpha_r <= alpha_sel;
      out_end_r   <= s1_end_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_blue      = out_blue_r;
  assign out_green     = out_green_r;
  assign out_red       = out_red_r;
  assign out_alpha     = out_alpha_r;
  assign out_frame_end = out_end_r;

endmodule

FILE: hw/rtl/mua_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mua_div
// Restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module mua_div #(
  parameter int DVD_W = 21,
  parameter int DVS_W = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder,
  output logic             done
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  logic [DVS_W:0] rem_sh;
  logic [DVS_W:0] rem_sub;
  logic           fits;

  assign rem_sh  = {rem_r, quo_r[DVD_W-1]};
  assign fits    = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(DVD_W);
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - CNT_W'(1);
        done_r <= (cnt_r == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], fits};
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule

FILE: bench/mask_upscale_alpha_apply_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mask_upscale_alpha_apply_core_tb
// Self-checking bench for the nearest-neighbor matte upscale / alpha apply.
// ----------------------------------------------------------------------------
// Loads mask samples and streams pixels through the core. A scoreboard keeps
// its own copy of the mask store, registers and raster counters, and predicts
// every pixel result in order. A directed opening covers pass-through, value
// clamping, saturated sizes and frame wrap. After that come random phases,
// each with its own configuration. The sender works in bursts and the
// receiver stalls on its own pattern, with one long hold that fills the core.
// ----------------------------------------------------------------------------
module mask_upscale_alpha_apply_core_tb;

  localparam int MASK_ENTRIES     = mua_pkg::MASK_DEPTH_DEF;
  localparam int RANDOM_REQUESTS  = 1050;
  localparam int DRAIN_CYCLES     = 16;
  localparam int LONG_HOLD_AT     = 300;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT      = 600000;

  // golden model of the matte path, fed with every accepted request
  class matte_scoreboard;
    typedef struct packed {
      logic [mua_pkg::CH_W-1:0] blue;
      logic [mua_pkg::CH_W-1:0] green;
      logic [mua_pkg::CH_W-1:0] red;
      logic [mua_pkg::CH_W-1:0] alpha;
      logic                     frame_end;
    } pixel_result_t;

    bit [16:0]                 sample_mem [MASK_ENTRIES];
    bit                        written [MASK_ENTRIES];
    bit                        enable;
    bit [mua_pkg::FRAME_W-1:0] frame_w;
    bit [mua_pkg::FRAME_W-1:0] frame_h;
    bit [mua_pkg::MDIM_W-1:0]  mask_w;
    bit [mua_pkg::MDIM_W-1:0]  mask_h;
    int unsigned               col;
    int unsigned               row;
    pixel_result_t             pixel_q [$];
    int                        errors;
    int unsigned               requests_seen;
    int unsigned               results_seen;

    function new();
      enable        = 1'b0;
      frame_w       = mua_pkg::FRAME_W_RST;
      frame_h       = mua_pkg::FRAME_H_RST;
      mask_w        = '0;
      mask_h        = '0;
      col           = 0;
      row           = 0;
      errors        = 0;
      requests_seen = 0;
      results_seen  = 0;
    endfunction

    function int unsigned eff_frame(bit [mua_pkg::FRAME_W-1:0] v);
      if (v == 0) return 1;
      if (v > mua_pkg::MAX_FRAME_DIM_DEF) return mua_pkg::MAX_FRAME_DIM_DEF;
      return v;
    endfunction

    function int unsigned eff_mask(bit [mua_pkg::MDIM_W-1:0] v);
      return (v > mua_pkg::MASK_DIM_MAX) ? mua_pkg::MASK_DIM_MAX : v;
    endfunction

    function bit reads_mask();
      return enable && mask_w != 0 && mask_h != 0;
    endfunction

    // mask entry the next pixel picks up
    function int unsigned next_read_pos();
      int unsigned mw;
      int unsigned mh;
      int unsigned mx;
      int unsigned my;
      mw = eff_mask(mask_w);
      mh = eff_mask(mask_h);
      mx = ((col * mw) & 32'h1FFFFF) / eff_frame(frame_w);
      my = ((row * mh) & 32'h1FFFFF) / eff_frame(frame_h);
      if (mx >= mw) mx = mw - 1;
      if (my >= mh) my = mh - 1;
      return my * mw + mx;
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction

    function void write_reg(logic [mua_pkg::CFG_IDX_W-1:0] idx,
                            logic [mua_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        mua_pkg::CFG_ENABLE:  enable  = data[0];
        mua_pkg::CFG_FRAME_W: frame_w = data[mua_pkg::FRAME_W-1:0];
        mua_pkg::CFG_FRAME_H: frame_h = data[mua_pkg::FRAME_W-1:0];
        mua_pkg::CFG_MASK_W:  mask_w  = data[mua_pkg::MDIM_W-1:0];
        mua_pkg::CFG_MASK_H:  mask_h  = data[mua_pkg::MDIM_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic op, logic [mua_pkg::MPOS_W-1:0] idx,
                               logic signed [mua_pkg::MVAL_W-1:0] val,
                               logic [mua_pkg::CH_W-1:0] b, logic [mua_pkg::CH_W-1:0] g,
                               logic [mua_pkg::CH_W-1:0] r, logic [mua_pkg::CH_W-1:0] a);
      int            sv;
      bit            last_col;
      bit            last_row;
      pixel_result_t px;
      requests_seen++;
      if (op == mua_pkg::OP_MASK_WR) begin
        sv = int'(val);
        if (sv < 0) sv = 0;
        if (sv > int'(mua_pkg::ONE_Q16)) sv = int'(mua_pkg::ONE_Q16);
        sample_mem[idx] = sv[16:0];
        written[idx]    = 1'b1;
        return;
      end
      px.blue  = b;
      px.green = g;
      px.red   = r;
      px.alpha = a;
      if (reads_mask())
        px.alpha = 8'((32'(sample_mem[next_read_pos()]) * 255) >> 16);
      last_col     = (col + 1) >= eff_frame(frame_w);
      last_row     = (row + 1) >= eff_frame(frame_h);
      px.frame_end = last_col && last_row;
      pixel_q      = {pixel_q, px};
      if (last_col) begin
        col = 0;
        row = last_row ? 0 : ((row + 1) & 32'hFFF);
      end else begin
        col = (col + 1) & 32'hFFF;
      end
    endfunction

    function void check_pixel(logic [mua_pkg::CH_W-1:0] b, logic [mua_pkg::CH_W-1:0] g,
                              logic [mua_pkg::CH_W-1:0] r, logic [mua_pkg::CH_W-1:0] a,
                              logic fe);
      pixel_result_t want;
      results_seen++;
      if (pixel_q.size() == 0) begin
        $error("pixel result with no request waiting");
        errors++;
        return;
      end
      want = pixel_q.pop_front();
      if (b !== want.blue) begin
        $error("out_blue expected %0d got %0d", want.blue, b);
        errors++;
      end
      if (g !== want.green) begin
        $error("out_green expected %0d got %0d", want.green, g);
        errors++;
      end
      if (r !== want.red) begin
        $error("out_red expected %0d got %0d", want.red, r);
        errors++;
      end
      if (a !== want.alpha) begin
        $error("out_alpha expected %0d got %0d", want.alpha, a);
        errors++;
      end
      if (fe !== want.frame_end) begin
        $error("out_frame_end expected %0d got %0d", want.frame_end, fe);
        errors++;
      end
    endfunction
  endclass

  logic                              clk;
  logic                              rst_n         = 1'b0;
  logic                              cfg_we        = 1'b0;
  logic [mua_pkg::CFG_IDX_W-1:0]     cfg_index     = mua_pkg::CFG_ENABLE;
  logic [mua_pkg::CFG_DATA_W-1:0]    cfg_wdata     = '0;
  logic                              in_valid      = 1'b0;
  logic                              in_stall;
  logic                              in_op         = mua_pkg::OP_PIXEL;
  logic [mua_pkg::MPOS_W-1:0]        in_mask_index = '0;
  logic signed [mua_pkg::MVAL_W-1:0] in_mask_value = '0;
  logic [mua_pkg::CH_W-1:0]          in_blue       = '0;
  logic [mua_pkg::CH_W-1:0]          in_green      = '0;
  logic [mua_pkg::CH_W-1:0]          in_red        = '0;
  logic [mua_pkg::CH_W-1:0]          in_alpha_in   = '0;
  logic                              out_valid;
  logic                              out_stall     = 1'b0;
  logic [mua_pkg::CH_W-1:0]          out_blue;
  logic [mua_pkg::CH_W-1:0]          out_green;
  logic [mua_pkg::CH_W-1:0]          out_red;
  logic [mua_pkg::CH_W-1:0]          out_alpha;
  logic                              out_frame_end;

  matte_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int          hold_left   = 0;
  bit          hold_done   = 1'b0;
  int          stall_mode  = 0;
  int          mode_timer  = 0;

  mask_upscale_alpha_apply_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_mask_index (in_mask_index),
    .in_mask_value (in_mask_value),
    .in_blue       (in_blue),
    .in_green      (in_green),
    .in_red        (in_red),
    .in_alpha_in   (in_alpha_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_blue      (out_blue),
    .out_green     (out_green),
    .out_red       (out_red),
    .out_alpha     (out_alpha),
    .out_frame_end (out_frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: check, then pick the next stall value
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_pixel(out_blue, out_green, out_red, out_alpha, out_frame_end);
    // start the long hold while the sender is offering requests
    if (!hold_done && sb.results_seen >= LONG_HOLD_AT && in_valid) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (mode_timer == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_timer = $urandom_range(16, 96);
    end else begin
      mode_timer--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 7) == 0);
        2: out_stall <= $urandom_range(0, 1);
        default: out_stall <= ($urandom_range(0, 15) < 12);
      endcase
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic signed [mua_pkg::MVAL_W-1:0] pick_mask_value();
    case ($urandom_range(0, 11))
      0: return 18'h20000;
      1: return 18'h1FFFF;
      2: return 18'h10000;
      3: return 18'h0FFFF;
      4: return 18'h3FFFF;
      5: return 18'h00000;
      6, 7: return 18'($urandom);
      default: return 18'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic int pick_frame_dim();
    case ($urandom_range(0, 19))
      0: return 0;
      1: return 8191;
      2: return mua_pkg::MAX_FRAME_DIM_DEF;
      3: return $urandom_range(mua_pkg::MAX_FRAME_DIM_DEF + 1, 8190);
      4, 5: return $urandom_range(17, 300);
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  function automatic int pick_mask_dim();
    case ($urandom_range(0, 11))
      0: return 0;
      1: return mua_pkg::MASK_DIM_MAX;
      2: return $urandom_range(mua_pkg::MASK_DIM_MAX + 1, 511);
      3: return 1;
      4, 5, 6: return $urandom_range(2, 255);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  task automatic send_request(logic op, logic [mua_pkg::MPOS_W-1:0] idx,
                              logic signed [mua_pkg::MVAL_W-1:0] val,
                              logic [mua_pkg::CH_W-1:0] b, logic [mua_pkg::CH_W-1:0] g,
                              logic [mua_pkg::CH_W-1:0] r, logic [mua_pkg::CH_W-1:0] a);
    in_valid      <= 1'b1;
    in_op         <= op;
    in_mask_index <= idx;
    in_mask_value <= val;
    in_blue       <= b;
    in_green      <= g;
    in_red        <= r;
    in_alpha_in   <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(op, idx, val, b, g, r, a);
  endtask

  task automatic send_mask_sample(logic [mua_pkg::MPOS_W-1:0] idx,
                                  logic signed [mua_pkg::MVAL_W-1:0] val);
    send_request(mua_pkg::OP_MASK_WR, idx, val, 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom));
  endtask

  // never let a pixel land on a mask entry that was not loaded yet
  task automatic send_pixel(logic [mua_pkg::CH_W-1:0] b, logic [mua_pkg::CH_W-1:0] g,
                            logic [mua_pkg::CH_W-1:0] r, logic [mua_pkg::CH_W-1:0] a);
    int unsigned pos;
    if (sb.reads_mask()) begin
      pos = sb.next_read_pos();
      if (!sb.written[pos]) send_mask_sample(16'(pos), pick_mask_value());
    end
    send_request(mua_pkg::OP_PIXEL, 16'($urandom), 18'($urandom), b, g, r, a);
  endtask

  task automatic send_random_pixel();
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // mask writes give no result, so allow the pipe to empty after the last one
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [mua_pkg::CFG_IDX_W-1:0] idx, int data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 13'(data);
    @(posedge clk);
    sb.write_reg(idx, 13'(data));
  endtask

  task automatic apply_config(bit en, int fw, int fh, int mw, int mh);
    write_reg(mua_pkg::CFG_ENABLE, en);
    write_reg(mua_pkg::CFG_FRAME_W, fw);
    write_reg(mua_pkg::CFG_FRAME_H, fh);
    write_reg(mua_pkg::CFG_MASK_W, mw);
    write_reg(mua_pkg::CFG_MASK_H, mh);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int unsigned stop_at);
    int unsigned phase_len;
    int unsigned area;
    int unsigned sent;
    int          burst_left;
    int          gap_max;
    logic [mua_pkg::MPOS_W-1:0] idx;
    wait_drained();
    apply_config($urandom_range(0, 4) != 0, pick_frame_dim(), pick_frame_dim(),
                 pick_mask_dim(), pick_mask_dim());
    phase_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 8) : $urandom_range(20, 120);
    gap_max    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    area       = sb.eff_mask(sb.mask_w) * sb.eff_mask(sb.mask_h);
    burst_left = $urandom_range(1, 40);
    sent       = 0;
    while (sent < phase_len && sb.requests_seen < stop_at) begin
      if ($urandom_range(0, 3) == 0) begin
        if (area != 0 && $urandom_range(0, 1) == 1)
          idx = 16'($urandom_range(0, area - 1));
        else
          idx = 16'($urandom);
        send_mask_sample(idx, pick_mask_value());
      end else begin
        send_random_pixel();
      end
      sent++;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 40);
        if (gap_max > 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, gap_max)) @(posedge clk);
        end
      end
    end
  endtask

  initial begin
    int unsigned stop_at;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset settings: matting off, no mask
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hAA, 8'h55, 8'hAA, 8'h55);
    send_mask_sample(16'd0, 18'h20000);
    wait_drained();

    // matting on but zero mask height, saturated frame sizes
    apply_config(1'b1, 0, 8191, 2, 0);
    send_pixel(8'h55, 8'hAA, 8'h55, 8'hAA);
    send_pixel(8'h01, 8'h80, 8'hFE, 8'h7F);
    wait_drained();

    // small frame over a 2x2 mask, clamped samples, frame wrap
    apply_config(1'b1, 4, 2, 2, 2);
    send_mask_sample(16'd0, 18'h20000);
    send_mask_sample(16'd1, 18'h1FFFF);
    send_mask_sample(16'd2, 18'h0FFFF);
    send_mask_sample(16'd3, 18'h10001);
    send_mask_sample(16'hFFFF, 18'h00001);
    repeat (8) send_random_pixel();
    wait_drained();

    // widest mask on the widest frame, one row high, mask sizes saturated
    apply_config(1'b1, 8191, 0, 511, 511);
    repeat (3) send_random_pixel();

    stop_at = sb.requests_seen + RANDOM_REQUESTS;
    while (sb.requests_seen < stop_at) random_phase(stop_at);
    wait_drained();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
